>>> src/ips_pkg.sv
// shared types, codes and defaults for the integer pixel replication scaler
// no dependencies; used by every module of the block
`default_nettype none

package ips_pkg;

    // default sizing of the block
    localparam int unsigned DEF_MAX_WIDTH  = 1024;
    localparam int unsigned DEF_MAX_SCALE  = 100;
    localparam int unsigned DEF_MAX_HEIGHT = 4096;

    // register field widths
    localparam int unsigned SCALE_W  = 7;
    localparam int unsigned WIDTH_W  = 11;
    localparam int unsigned HEIGHT_W = 13;
    localparam int unsigned CFG_DW   = 13;
    localparam int unsigned CFG_IW   = 2;

    // pixel layout
    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned PIXEL_W = 3 * CHAN_W;

    // register reset values before clamping
    localparam int unsigned RST_SCALE  = 1;
    localparam int unsigned RST_WIDTH  = 1024;
    localparam int unsigned RST_HEIGHT = 1;

    // register indexes
    localparam logic [CFG_IW-1:0] REG_SCALE  = 2'd0;
    localparam logic [CFG_IW-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IW-1:0] REG_HEIGHT = 2'd2;

    // operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_PULL = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BUSY  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // clamped register values
    typedef struct packed {
        logic [SCALE_W-1:0]  scale;
        logic [WIDTH_W-1:0]  width;
        logic [HEIGHT_W-1:0] height;
    } t_cfg;

    // per-item result control from the sequencer
    typedef struct packed {
        t_status status;
        logic    pull_ok;
        logic    eor;
        logic    eof;
    } t_info;

endpackage

`default_nettype wire

>>> src/ips_cfg.sv
// configuration registers of the scaler, clamped into their legal range on write
// depends on ips_pkg
`default_nettype none

module ips_cfg #(
    parameter int unsigned MAX_WIDTH  = ips_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_SCALE  = ips_pkg::DEF_MAX_SCALE,
    parameter int unsigned MAX_HEIGHT = ips_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [ips_pkg::CFG_IW-1:0]  i_cfg_index,
    input  wire logic [ips_pkg::CFG_DW-1:0]  i_cfg_data,
    output ips_pkg::t_cfg                    o_cfg
);

    // zero acts as one, anything above the top acts as the top
    function automatic int unsigned clamp_val(int unsigned v, int unsigned top);
        int unsigned res;
        res = v;
        if (v == 0) begin
            res = 1;
        end else if (v > top) begin
            res = top;
        end
        return res;
    endfunction

    ips_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scale  <= ips_pkg::SCALE_W'(clamp_val(ips_pkg::RST_SCALE, MAX_SCALE));
            r_cfg.width  <= ips_pkg::WIDTH_W'(clamp_val(ips_pkg::RST_WIDTH, MAX_WIDTH));
            r_cfg.height <= ips_pkg::HEIGHT_W'(clamp_val(ips_pkg::RST_HEIGHT, MAX_HEIGHT));
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ips_pkg::REG_SCALE: begin
                    r_cfg.scale <= ips_pkg::SCALE_W'(clamp_val(
                        32'(i_cfg_data[ips_pkg::SCALE_W-1:0]), MAX_SCALE));
                end
                ips_pkg::REG_WIDTH: begin
                    r_cfg.width <= ips_pkg::WIDTH_W'(clamp_val(
                        32'(i_cfg_data[ips_pkg::WIDTH_W-1:0]), MAX_WIDTH));
                end
                ips_pkg::REG_HEIGHT: begin
                    r_cfg.height <= ips_pkg::HEIGHT_W'(clamp_val(
                        32'(i_cfg_data[ips_pkg::HEIGHT_W-1:0]), MAX_HEIGHT));
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> src/ips_line_mem.sv
// one-row line store: one write port, one read port with registered read data
// depends on ips_pkg
`default_nettype none

module ips_line_mem #(
    parameter int unsigned DEPTH = ips_pkg::DEF_MAX_WIDTH,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_we,
    input  wire logic [AW-1:0]                i_waddr,
    input  wire logic [ips_pkg::PIXEL_W-1:0]  i_wdata,
    input  wire logic                         i_re,
    input  wire logic [AW-1:0]                i_raddr,
    output logic      [ips_pkg::PIXEL_W-1:0]  o_rdata
);

    logic [ips_pkg::PIXEL_W-1:0] r_mem [DEPTH];
    logic [ips_pkg::PIXEL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> src/ips_ctrl.sv
// load and pull sequencer: column, repeat and row counters, line store addressing
// depends on ips_pkg
`default_nettype none

module ips_ctrl #(
    parameter int unsigned MAX_WIDTH  = ips_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_SCALE  = ips_pkg::DEF_MAX_SCALE,
    parameter int unsigned MAX_HEIGHT = ips_pkg::DEF_MAX_HEIGHT,
    parameter int unsigned AW         = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_fire,
    input  wire logic          i_op,
    input  ips_pkg::t_cfg      i_cfg,
    output logic               o_wr_en,
    output logic [AW-1:0]      o_wr_addr,
    output logic [AW-1:0]      o_rd_addr,
    output ips_pkg::t_info     o_info
);

    localparam int unsigned SW = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
    localparam int unsigned HW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    logic          r_row_ready, n_row_ready;
    logic [AW-1:0] r_load_col,  n_load_col;
    logic [AW-1:0] r_read_col,  n_read_col;
    logic [SW-1:0] r_hrep,      n_hrep;
    logic [SW-1:0] r_vrep,      n_vrep;
    logic [HW-1:0] r_src_row,   n_src_row;

    logic          w_last_rep, w_last_col, w_last_vrep, w_last_row;
    logic [AW:0]   w_load_next;

    // counters that overshoot a shrunk register count as the last position
    assign w_last_rep  = 32'(r_hrep) + 32'd1 >= 32'(i_cfg.scale);
    assign w_last_col  = 32'(r_read_col) + 32'd1 >= 32'(i_cfg.width);
    assign w_last_vrep = 32'(r_vrep) + 32'd1 >= 32'(i_cfg.scale);
    assign w_last_row  = 32'(r_src_row) + 32'd1 >= 32'(i_cfg.height);
    assign w_load_next = {1'b0, r_load_col} + (AW+1)'(1);

    always_comb begin
        n_row_ready = r_row_ready;
        n_load_col  = r_load_col;
        n_read_col  = r_read_col;
        n_hrep      = r_hrep;
        n_vrep      = r_vrep;
        n_src_row   = r_src_row;
        o_wr_en     = 1'b0;
        o_info      = '{status: ips_pkg::ST_OK, pull_ok: 1'b0, eor: 1'b0, eof: 1'b0};

        if (i_op == ips_pkg::OP_LOAD) begin
            if (r_row_ready) begin
                o_info.status = ips_pkg::ST_BUSY;
            end else begin
                o_wr_en = i_fire;
                if (32'(w_load_next) >= 32'(i_cfg.width)) begin
                    n_load_col  = '0;
                    n_row_ready = 1'b1;
                    n_read_col  = '0;
                    n_hrep      = '0;
                    n_vrep      = '0;
                end else begin
                    n_load_col = w_load_next[AW-1:0];
                end
            end
        end else if (!r_row_ready) begin
            o_info.status = ips_pkg::ST_EMPTY;
        end else begin
            o_info.pull_ok = 1'b1;
            o_info.eor     = w_last_rep && w_last_col;
            o_info.eof     = w_last_rep && w_last_col && w_last_vrep && w_last_row;
            if (!w_last_rep) begin
                n_hrep = r_hrep + SW'(1);
            end else begin
                n_hrep = '0;
                if (!w_last_col) begin
                    n_read_col = r_read_col + AW'(1);
                end else begin
                    n_read_col = '0;
                    if (!w_last_vrep) begin
                        n_vrep = r_vrep + SW'(1);
                    end else begin
                        n_vrep      = '0;
                        n_row_ready = 1'b0;
                        n_src_row   = w_last_row ? '0 : r_src_row + HW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_ready <= 1'b0;
            r_load_col  <= '0;
            r_read_col  <= '0;
            r_hrep      <= '0;
            r_vrep      <= '0;
            r_src_row   <= '0;
        end else if (i_fire) begin
            r_row_ready <= n_row_ready;
            r_load_col  <= n_load_col;
            r_read_col  <= n_read_col;
            r_hrep      <= n_hrep;
            r_vrep      <= n_vrep;
            r_src_row   <= n_src_row;
        end
    end

    assign o_wr_addr = r_load_col;
    assign o_rd_addr = r_read_col;

endmodule

`default_nettype wire

>>> src/integer_pixel_replication_scaler.sv
// Nearest-neighbor integer upscaler. Loads fill a one-row line store, pulls stream the
// output pixels in raster order with every pixel and every row repeated scale_factor
// times. Each accepted item gives one result via the registered line store read and then
// the output register. The block takes one item per clock unless the output stalls,
// limited by the single read and single write port of the line store, and keeps taking
// items while a result waits in the output register as long as the read stage is free.
// Registers must be written only while the block is idle; the block does not enforce it.
// depends on ips_pkg, ips_cfg, ips_ctrl, ips_line_mem
`default_nettype none

module integer_pixel_replication_scaler #(
    parameter int unsigned MAX_WIDTH  = ips_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_SCALE  = ips_pkg::DEF_MAX_SCALE,
    parameter int unsigned MAX_HEIGHT = ips_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [ips_pkg::CFG_IW-1:0]  i_cfg_index,
    input  wire logic [ips_pkg::CFG_DW-1:0]  i_cfg_data,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic                        i_operation,
    input  wire logic [7:0]                  i_blue_in,
    input  wire logic [7:0]                  i_green_in,
    input  wire logic [7:0]                  i_red_in,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [1:0]                       o_status,
    output logic [7:0]                       o_blue_out,
    output logic [7:0]                       o_green_out,
    output logic [7:0]                       o_red_out,
    output logic                             o_end_of_row,
    output logic                             o_end_of_frame
);

    localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    ips_pkg::t_cfg               w_cfg;
    ips_pkg::t_info              w_info;
    logic                        w_fire;
    logic                        w_move;
    logic                        w_wr_en;
    logic [AW-1:0]               w_wr_addr;
    logic [AW-1:0]               w_rd_addr;
    logic [ips_pkg::PIXEL_W-1:0] w_rdata;

    logic                        r_s1_valid;
    ips_pkg::t_info              r_s1_info;
    logic                        r_out_valid;
    logic [1:0]                  r_status;
    logic [7:0]                  r_blue;
    logic [7:0]                  r_green;
    logic [7:0]                  r_red;
    logic                        r_eor;
    logic                        r_eof;

    // read stage moves on when the output register is empty or being taken
    assign w_move  = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_s1_valid || w_move;
    assign w_fire  = i_valid && o_ready;

    ips_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_SCALE  (MAX_SCALE),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    ips_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_SCALE  (MAX_SCALE),
        .MAX_HEIGHT (MAX_HEIGHT),
        .AW         (AW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (w_fire),
        .i_op      (i_operation),
        .i_cfg     (w_cfg),
        .o_wr_en   (w_wr_en),
        .o_wr_addr (w_wr_addr),
        .o_rd_addr (w_rd_addr),
        .o_info    (w_info)
    );

    // a pull right after the completing load sees the written entry, the write lands first
    ips_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_wr_en),
        .i_waddr (w_wr_addr),
        .i_wdata ({i_red_in, i_green_in, i_blue_in}),
        .i_re    (w_fire),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_s1_valid <= 1'b1;
            end else if (w_move) begin
                r_s1_valid <= 1'b0;
            end
            if (w_move) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_s1_info <= w_info;
        end
        if (w_move) begin
            r_status <= r_s1_info.status;
            r_eor    <= r_s1_info.eor;
            r_eof    <= r_s1_info.eof;
            r_red    <= r_s1_info.pull_ok ? w_rdata[3*ips_pkg::CHAN_W-1:2*ips_pkg::CHAN_W] : '0;
            r_green  <= r_s1_info.pull_ok ? w_rdata[2*ips_pkg::CHAN_W-1:ips_pkg::CHAN_W] : '0;
            r_blue   <= r_s1_info.pull_ok ? w_rdata[ips_pkg::CHAN_W-1:0] : '0;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_blue_out     = r_blue;
    assign o_green_out    = r_green;
    assign o_red_out      = r_red;
    assign o_end_of_row   = r_eor;
    assign o_end_of_frame = r_eof;

endmodule

`default_nettype wire

>>> src/ips_checker.sv
// port-level checks for the scaler, bound to the top level
// depends on ips_pkg and integer_pixel_replication_scaler
`default_nettype none

module ips_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_ready,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic [1:0] o_status,
    input wire logic [7:0] o_blue_out,
    input wire logic [7:0] o_green_out,
    input wire logic [7:0] o_red_out,
    input wire logic       o_end_of_row,
    input wire logic       o_end_of_frame
);

    // any accepted item has a result showing after the line store read and output registers
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |-> ##2 o_valid)
        else $error("no result two cycles after input transfer");

    // input stalls only when a result is backed up at the output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("input stalled with free output");

    // anything but an ok pull carries zero pixel and no marks
    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ips_pkg::ST_OK |->
            o_blue_out == 8'd0 && o_green_out == 8'd0 && o_red_out == 8'd0
            && !o_end_of_row && !o_end_of_frame)
        else $error("non-ok result with pixel data or marks");

    a_eof_in_eor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_end_of_frame |-> o_end_of_row)
        else $error("end of frame without end of row");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_blue_out)
            && $stable(o_green_out) && $stable(o_red_out))
        else $error("stalled result changed");

endmodule

bind integer_pixel_replication_scaler ips_checker u_ips_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_status       (o_status),
    .o_blue_out     (o_blue_out),
    .o_green_out    (o_green_out),
    .o_red_out      (o_red_out),
    .o_end_of_row   (o_end_of_row),
    .o_end_of_frame (o_end_of_frame)
);

`default_nettype wire

>>> bench/integer_pixel_replication_scaler_tb.sv
// testbench for the integer pixel replication scaler: directed and random load/pull traffic
// with random stalls on both sides, checked against a cycle-free model of the line store
// depends on ips_pkg and integer_pixel_replication_scaler
`timescale 1ns / 1ps

module integer_pixel_replication_scaler_tb;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int USEFUL_TARGET = 950;
    localparam int SETTLE_CYCLES = 4;

    typedef struct packed {
        ips_pkg::t_status           status;
        logic [ips_pkg::CHAN_W-1:0] blue;
        logic [ips_pkg::CHAN_W-1:0] green;
        logic [ips_pkg::CHAN_W-1:0] red;
        logic                       eor;
        logic                       eof;
    } t_pixel_result;

    // replication model plus the queue of pixels still owed by the block
    class scaler_scoreboard;
        logic [ips_pkg::PIXEL_W-1:0]  line_store [ips_pkg::DEF_MAX_WIDTH];
        logic [ips_pkg::SCALE_W-1:0]  scale_reg;
        logic [ips_pkg::WIDTH_W-1:0]  width_reg;
        logic [ips_pkg::HEIGHT_W-1:0] height_reg;
        logic [10:0]                  load_col;
        bit                           row_held;
        logic [9:0]                   read_col;
        logic [6:0]                   h_rep;
        logic [6:0]                   v_rep;
        logic [11:0]                  src_row;
        int unsigned                  filled;
        t_pixel_result                owed [$];
        int                           errors;

        function new();
            scale_reg  = ips_pkg::SCALE_W'(ips_pkg::RST_SCALE);
            width_reg  = ips_pkg::WIDTH_W'(ips_pkg::RST_WIDTH);
            height_reg = ips_pkg::HEIGHT_W'(ips_pkg::RST_HEIGHT);
            load_col   = '0;
            row_held   = 1'b0;
            read_col   = '0;
            h_rep      = '0;
            v_rep      = '0;
            src_row    = '0;
            filled     = 0;
            errors     = 0;
        endfunction

        function int unsigned clamped(int unsigned v, int unsigned top);
            if (v == 0) return 1;
            if (v > top) return top;
            return v;
        endfunction

        function void set_reg(logic [ips_pkg::CFG_IW-1:0] idx, logic [ips_pkg::CFG_DW-1:0] data);
            unique case (idx)
                ips_pkg::REG_SCALE:  scale_reg  = data[ips_pkg::SCALE_W-1:0];
                ips_pkg::REG_WIDTH:  width_reg  = data[ips_pkg::WIDTH_W-1:0];
                ips_pkg::REG_HEIGHT: height_reg = data[ips_pkg::HEIGHT_W-1:0];
                default: ;
            endcase
        endfunction

        // a wider row while one is held would read entries never written
        function bit width_fits(logic [ips_pkg::CFG_DW-1:0] data);
            return !row_held
                || clamped(32'(data[ips_pkg::WIDTH_W-1:0]), ips_pkg::DEF_MAX_WIDTH) <= filled;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        function void note_input(logic op, logic [7:0] b, logic [7:0] g, logic [7:0] r);
            t_pixel_result res;
            int unsigned   s, w, h;
            logic [ips_pkg::PIXEL_W-1:0] px;
            bit last_rep, last_col, last_vrep, last_row;
            res = '0;
            res.status = ips_pkg::ST_OK;
            s = clamped(32'(scale_reg), ips_pkg::DEF_MAX_SCALE);
            w = clamped(32'(width_reg), ips_pkg::DEF_MAX_WIDTH);
            h = clamped(32'(height_reg), ips_pkg::DEF_MAX_HEIGHT);
            if (op == ips_pkg::OP_LOAD) begin
                if (row_held) begin
                    res.status = ips_pkg::ST_BUSY;
                end else begin
                    if (load_col < ips_pkg::DEF_MAX_WIDTH) begin
                        line_store[load_col[9:0]] = {r, g, b};
                        if (load_col + 1 > filled) filled = load_col + 1;
                    end
                    load_col++;
                    if (load_col >= w) begin
                        load_col = '0;
                        row_held = 1'b1;
                        read_col = '0;
                        h_rep    = '0;
                        v_rep    = '0;
                    end
                end
            end else if (!row_held) begin
                res.status = ips_pkg::ST_EMPTY;
            end else begin
                px = line_store[read_col];
                // counters past a shrunken limit count as being at the limit
                last_rep  = h_rep >= s - 1;
                last_col  = read_col >= w - 1;
                last_vrep = v_rep >= s - 1;
                last_row  = src_row >= h - 1;
                res.blue  = px[7:0];
                res.green = px[15:8];
                res.red   = px[23:16];
                res.eor   = last_rep && last_col;
                res.eof   = last_rep && last_col && last_vrep && last_row;
                if (!last_rep) begin
                    h_rep++;
                end else begin
                    h_rep = '0;
                    if (!last_col) begin
                        read_col++;
                    end else begin
                        read_col = '0;
                        if (!last_vrep) begin
                            v_rep++;
                        end else begin
                            v_rep    = '0;
                            row_held = 1'b0;
                            src_row  = last_row ? 12'd0 : src_row + 12'd1;
                        end
                    end
                end
            end
            owed.push_back(res);
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task compare_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        endtask

        task check_result(logic [1:0] st, logic [7:0] b, logic [7:0] g, logic [7:0] r,
                          logic eor, logic eof);
            t_pixel_result want;
            if (owed.size() == 0) begin
                report_mismatch("result transfer with nothing pending");
            end else begin
                want = owed.pop_front();
                compare_field("status", 8'(st), 8'(want.status));
                compare_field("blue", b, want.blue);
                compare_field("green", g, want.green);
                compare_field("red", r, want.red);
                compare_field("end_of_row", 8'(eor), 8'(want.eor));
                compare_field("end_of_frame", 8'(eof), 8'(want.eof));
            end
        endtask
    endclass

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_cfg_we;
    logic [ips_pkg::CFG_IW-1:0]   i_cfg_index;
    logic [ips_pkg::CFG_DW-1:0]   i_cfg_data;
    logic                         i_valid;
    logic                         o_ready;
    logic                         i_operation;
    logic [7:0]                   i_blue_in;
    logic [7:0]                   i_green_in;
    logic [7:0]                   i_red_in;
    logic                         o_valid;
    logic                         i_ready;
    logic [1:0]                   o_status;
    logic [7:0]                   o_blue_out;
    logic [7:0]                   o_green_out;
    logic [7:0]                   o_red_out;
    logic                         o_end_of_row;
    logic                         o_end_of_frame;

    scaler_scoreboard sb = new();
    int send_idle_pct;
    int recv_idle_pct;
    int useful_items;
    int cycles;

    integer_pixel_replication_scaler uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_operation    (i_operation),
        .i_blue_in      (i_blue_in),
        .i_green_in     (i_green_in),
        .i_red_in       (i_red_in),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_blue_out     (o_blue_out),
        .o_green_out    (o_green_out),
        .o_red_out      (o_red_out),
        .o_end_of_row   (o_end_of_row),
        .o_end_of_frame (o_end_of_frame)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // output stalls
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // results are checked before the input transfer of the same edge is modeled
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid === 1'b1 && i_ready)
                sb.check_result(o_status, o_blue_out, o_green_out, o_red_out,
                                o_end_of_row, o_end_of_frame);
            if (i_valid && o_ready === 1'b1)
                sb.note_input(i_operation, i_blue_in, i_green_in, i_red_in);
        end
    end

    // called and returns at a falling edge
    task send_item(logic op, logic [7:0] b, logic [7:0] g, logic [7:0] r);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_operation <= op;
        i_blue_in   <= b;
        i_green_in  <= g;
        i_red_in    <= r;
        forever begin
            @(posedge i_clk);
            if (o_ready === 1'b1) break;
        end
        @(negedge i_clk);
    endtask

    task wait_for_drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task write_reg(logic [ips_pkg::CFG_IW-1:0] idx, logic [ips_pkg::CFG_DW-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        sb.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task reconfigure();
        logic [ips_pkg::CFG_DW-1:0] v;
        int pick;
        wait_for_drain();
        if ($urandom_range(0, 1)) begin
            pick = $urandom_range(0, 9);
            if (pick < 7)      v = ips_pkg::CFG_DW'($urandom_range(1, 4));
            else if (pick < 8) v = '0;
            else if (pick < 9) v = ips_pkg::CFG_DW'($urandom_range(101, 127));
            else               v = ips_pkg::CFG_DW'($urandom_range(5, 100));
            // bits above the register width must be dropped
            if ($urandom_range(0, 3) == 0) v = v | ips_pkg::CFG_DW'($urandom & 32'h1F80);
            write_reg(ips_pkg::REG_SCALE, v);
        end
        if ($urandom_range(0, 1)) begin
            pick = $urandom_range(0, 19);
            if (pick < 14)      v = ips_pkg::CFG_DW'($urandom_range(1, 6));
            else if (pick < 16) v = '0;
            else if (pick < 18) v = ips_pkg::CFG_DW'($urandom_range(7, 64));
            else if (pick < 19) v = ips_pkg::CFG_DW'(ips_pkg::DEF_MAX_WIDTH);
            else                v = ips_pkg::CFG_DW'($urandom_range(1025, 2047));
            if ($urandom_range(0, 3) == 0) v = v | ips_pkg::CFG_DW'($urandom & 32'h1800);
            if (sb.width_fits(v)) write_reg(ips_pkg::REG_WIDTH, v);
        end
        if ($urandom_range(0, 1)) begin
            pick = $urandom_range(0, 19);
            if (pick < 12)      v = ips_pkg::CFG_DW'($urandom_range(1, 4));
            else if (pick < 14) v = '0;
            else if (pick < 17) v = ips_pkg::CFG_DW'(ips_pkg::DEF_MAX_HEIGHT);
            else                v = ips_pkg::CFG_DW'($urandom_range(4097, 8191));
            write_reg(ips_pkg::REG_HEIGHT, v);
        end
    endtask

    // mostly well-formed rows: fill while empty, drain while held, some misuse mixed in
    task send_random_item();
        logic op;
        if (sb.row_held) op = ($urandom_range(0, 9) == 0) ? ips_pkg::OP_LOAD : ips_pkg::OP_PULL;
        else             op = ($urandom_range(0, 6) == 0) ? ips_pkg::OP_PULL : ips_pkg::OP_LOAD;
        if ((op == ips_pkg::OP_LOAD) != sb.row_held) useful_items++;
        send_item(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = ips_pkg::REG_SCALE;
        i_cfg_data    = '0;
        i_valid       = 1'b0;
        i_operation   = ips_pkg::OP_LOAD;
        i_blue_in     = '0;
        i_green_in    = '0;
        i_red_in      = '0;
        i_ready       = 1'b0;
        send_idle_pct = 24;
        recv_idle_pct = 62;
        useful_items  = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // pull before anything is loaded, then a partial row at the reset width
        send_item(ips_pkg::OP_PULL, 8'hFF, 8'hFF, 8'hFF);
        send_item(ips_pkg::OP_LOAD, 8'h00, 8'h00, 8'h00);
        send_item(ips_pkg::OP_LOAD, 8'hFF, 8'hFF, 8'hFF);
        send_item(ips_pkg::OP_LOAD, 8'hA5, 8'h5A, 8'hC3);
        wait_for_drain();
        write_reg(ips_pkg::REG_WIDTH, 13'd2047);
        write_reg(ips_pkg::REG_WIDTH, 13'd4);
        write_reg(ips_pkg::REG_SCALE, 13'd0);
        write_reg(ips_pkg::REG_HEIGHT, 13'd0);
        // completes the row, then a load against a held row
        send_item(ips_pkg::OP_LOAD, 8'h3C, 8'hC3, 8'h0F);
        send_item(ips_pkg::OP_LOAD, 8'h12, 8'h34, 8'h56);
        repeat (4) send_item(ips_pkg::OP_PULL, 8'h00, 8'h00, 8'h00);
        send_item(ips_pkg::OP_PULL, 8'h00, 8'h00, 8'h00);

        // top scale and height, then shrink scale mid-row
        wait_for_drain();
        write_reg(ips_pkg::REG_SCALE, 13'd127);
        write_reg(ips_pkg::REG_WIDTH, 13'd0);
        write_reg(ips_pkg::REG_HEIGHT, 13'd8191);
        send_item(ips_pkg::OP_LOAD, 8'hF0, 8'h0F, 8'h99);
        repeat (3) send_item(ips_pkg::OP_PULL, 8'h55, 8'hAA, 8'h55);
        wait_for_drain();
        write_reg(ips_pkg::REG_SCALE, 13'd100);
        repeat (2) send_item(ips_pkg::OP_PULL, 8'h00, 8'h00, 8'h00);
        wait_for_drain();
        write_reg(ips_pkg::REG_SCALE, 13'd2);
        write_reg(ips_pkg::REG_HEIGHT, ips_pkg::CFG_DW'(ips_pkg::DEF_MAX_HEIGHT));
        repeat (3) send_item(ips_pkg::OP_PULL, 8'h00, 8'h00, 8'h00);

        // source row counter now past a shrunken frame height
        wait_for_drain();
        write_reg(ips_pkg::REG_HEIGHT, 13'd1);
        write_reg(ips_pkg::REG_WIDTH, ips_pkg::CFG_DW'(ips_pkg::DEF_MAX_WIDTH));
        send_item(ips_pkg::OP_LOAD, 8'h01, 8'h80, 8'h7F);
        send_item(ips_pkg::OP_LOAD, 8'hFE, 8'h7F, 8'h80);
        wait_for_drain();
        write_reg(ips_pkg::REG_WIDTH, 13'd2);
        send_item(ips_pkg::OP_LOAD, 8'h81, 8'h18, 8'hE7);

        while (useful_items < USEFUL_TARGET) begin
            if (useful_items >= 2 * USEFUL_TARGET / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else if (useful_items >= USEFUL_TARGET / 3) begin
                send_idle_pct = 62;
                recv_idle_pct = 24;
            end
            reconfigure();
            repeat ($urandom_range(10, 60)) send_random_item();
        end

        wait_for_drain();
        repeat (8) @(negedge i_clk);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> sim.f
src/ips_pkg.sv
src/ips_cfg.sv
src/ips_line_mem.sv
src/ips_ctrl.sv
src/integer_pixel_replication_scaler.sv
src/ips_checker.sv
bench/integer_pixel_replication_scaler_tb.sv
